// ===== design/running_median_two_heaps_macros.svh =====
// Assertion macros for the running median block.
// Used by running_median_two_heaps.sv; expects clk and rst_n in scope.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH

// Condition implies consequence in the same cycle.
`define RMTH_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("running median assertion failed");

// Condition implies consequence in the next cycle.
`define RMTH_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("running median assertion failed");

`endif

// ===== design/rmth_pkg.sv =====
// Package for the running median block: parameter defaults.
// No dependencies.
package rmth_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 32;

endpackage

// ===== design/running_median_two_heaps.sv =====
// Running lower median over two heaps, top level.
// Depends on rmth_pkg, rmth_ram and running_median_two_heaps_macros.svh.
//
// Each accepted word (sample, restart) adds one signed value and returns one word with the
// lower median of all held values, the held count and a dropped flag (store full). A
// sequencer runs at most two heap operations per sample on two RAMs (max-heap of the
// lower half, min-heap of the upper half): a push climbs and a top replacement
// descends level by level, and every level needs registered reads of the heap RAM
// (the parent for a push, both children for a replacement). A dropped sample goes
// from ST_DECIDE straight to ST_OUT. Input stall is high while a sample is in work;
// one finished result can wait in the output register while the next sample is taken.
// No clearing pass is needed after reset.
`include "running_median_two_heaps_macros.svh"

module running_median_two_heaps #(
    parameter int CAPACITY    = rmth_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF,
    parameter int HW          = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] median,
    output logic [HW-1:0]                 held_count,
    output logic                          dropped
);

    import rmth_pkg::*;

    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int AW         = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CW         = $clog2(HALF_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_P_RD, ST_P_CMP, ST_R_RDL, ST_R_RDR, ST_R_CMP, ST_OUT
    } state_t;

    typedef logic signed [SAMPLE_BITS-1:0] key_t;

    state_t        state_reg;
    key_t          sample_reg, key_reg, pend_key_reg, lval_reg, ltop_reg, utop_reg;
    logic [CW-1:0] lc_reg, uc_reg, idx_reg;
    logic          sel_reg, pend_reg, pend_sel_reg, drop_reg;
    logic          out_valid_reg, out_drop_reg;
    key_t          out_median_reg;
    logic [HW-1:0] out_held_reg;

    // RAM control
    logic          wr_en, step_done;
    logic [AW-1:0] wr_addr, rd_addr;
    key_t          wr_data, rd_data, l_rdata, u_rdata;
    logic [CW-1:0] step_idx;
    logic [CW:0]   l_idx, r_idx, cnt_ext;
    logic          has_l, has_r;
    logic [CW-1:0] parent, cnt_cur;
    logic [HW-1:0] held;

    // heap order: lower half is a max-heap, upper half a min-heap
    function automatic logic ranks_above(input logic upper, input key_t a, input key_t b);
        return upper ? (a < b) : (a > b);
    endfunction

    assign rd_data = sel_reg ? u_rdata : l_rdata;
    assign cnt_cur = sel_reg ? uc_reg : lc_reg;
    assign cnt_ext = {1'b0, cnt_cur};
    assign l_idx   = {idx_reg, 1'b1};
    assign r_idx   = l_idx + 1'b1;
    assign has_l   = l_idx < cnt_ext;
    assign has_r   = r_idx < cnt_ext;
    assign parent  = (idx_reg - 1'b1) >> 1;
    assign held    = HW'(lc_reg) + HW'(uc_reg);

    // one heap step per state
    always_comb
    begin
        key_t bv;
        wr_en     = 1'b0;
        wr_addr   = idx_reg[AW-1:0];
        wr_data   = key_reg;
        rd_addr   = parent[AW-1:0];
        step_done = 1'b0;
        step_idx  = idx_reg;
        bv        = key_reg;
        unique case (state_reg)
            ST_P_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en     = 1'b1;
                    step_done = 1'b1;
                end
            end
            ST_P_CMP:
            begin
                wr_en = 1'b1;
                if (ranks_above(sel_reg, key_reg, rd_data))
                begin
                    wr_data  = rd_data;
                    step_idx = parent;
                end
                else
                begin
                    step_done = 1'b1;
                end
            end
            ST_R_RDL:
            begin
                rd_addr = l_idx[AW-1:0];
                if (!has_l)
                begin
                    wr_en     = 1'b1;
                    step_done = 1'b1;
                end
            end
            ST_R_RDR:
            begin
                rd_addr = r_idx[AW-1:0];
            end
            ST_R_CMP:
            begin
                wr_en = 1'b1;
                if (ranks_above(sel_reg, lval_reg, bv))
                begin
                    bv       = lval_reg;
                    step_idx = l_idx[CW-1:0];
                end
                if (has_r && ranks_above(sel_reg, rd_data, bv))
                begin
                    bv       = rd_data;
                    step_idx = r_idx[CW-1:0];
                end
                wr_data = bv;
                if (step_idx == idx_reg)
                begin
                    step_done = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    rmth_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HALF_DEPTH), .AW(AW)) u_lower_ram (
        .clk   (clk),
        .we    (wr_en && !sel_reg),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (l_rdata)
    );

    rmth_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HALF_DEPTH), .AW(AW)) u_upper_ram (
        .clk   (clk),
        .we    (wr_en && sel_reg),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (u_rdata)
    );

    // sequencer, counts, cached tops and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lc_reg        <= '0;
            uc_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // output word: load a new one or retire the taken one
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // cached heap tops follow root writes
            if (wr_en && idx_reg == '0)
            begin
                if (sel_reg)
                begin
                    utop_reg <= wr_data;
                end
                else
                begin
                    ltop_reg <= wr_data;
                end
            end
            if (state_reg == ST_R_RDR)
            begin
                lval_reg <= rd_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample;
                        if (restart)
                        begin
                            lc_reg <= '0;
                            uc_reg <= '0;
                        end
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    drop_reg <= (held >= HW'(CAPACITY));
                    key_reg  <= sample_reg;
                    if (held >= HW'(CAPACITY))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else if (lc_reg == '0 || sample_reg <= ltop_reg)
                    begin
                        if (lc_reg > uc_reg)
                        begin
                            // replace lower top, old top goes up
                            sel_reg      <= 1'b0;
                            idx_reg      <= '0;
                            pend_reg     <= 1'b1;
                            pend_sel_reg <= 1'b1;
                            pend_key_reg <= ltop_reg;
                            state_reg    <= ST_R_RDL;
                        end
                        else
                        begin
                            sel_reg   <= 1'b0;
                            idx_reg   <= lc_reg;
                            lc_reg    <= lc_reg + 1'b1;
                            state_reg <= ST_P_RD;
                        end
                    end
                    else if (uc_reg >= lc_reg)
                    begin
                        if (uc_reg != '0 && sample_reg > utop_reg)
                        begin
                            // replace upper top, old top goes down
                            sel_reg      <= 1'b1;
                            idx_reg      <= '0;
                            pend_reg     <= 1'b1;
                            pend_sel_reg <= 1'b0;
                            pend_key_reg <= utop_reg;
                            state_reg    <= ST_R_RDL;
                        end
                        else
                        begin
                            sel_reg   <= 1'b0;
                            idx_reg   <= lc_reg;
                            lc_reg    <= lc_reg + 1'b1;
                            state_reg <= ST_P_RD;
                        end
                    end
                    else
                    begin
                        sel_reg   <= 1'b1;
                        idx_reg   <= uc_reg;
                        uc_reg    <= uc_reg + 1'b1;
                        state_reg <= ST_P_RD;
                    end
                end
                ST_P_RD, ST_P_CMP, ST_R_RDL, ST_R_CMP:
                begin
                    if (step_done && pend_reg)
                    begin
                        // queued push into the other half
                        pend_reg  <= 1'b0;
                        sel_reg   <= pend_sel_reg;
                        key_reg   <= pend_key_reg;
                        state_reg <= ST_P_RD;
                        if (pend_sel_reg)
                        begin
                            idx_reg <= uc_reg;
                            uc_reg  <= uc_reg + 1'b1;
                        end
                        else
                        begin
                            idx_reg <= lc_reg;
                            lc_reg  <= lc_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        idx_reg <= step_idx;
                        if (step_done)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else if (state_reg == ST_P_RD)
                        begin
                            state_reg <= ST_P_CMP;
                        end
                        else if (state_reg == ST_P_CMP)
                        begin
                            state_reg <= ST_P_RD;
                        end
                        else if (state_reg == ST_R_RDL)
                        begin
                            state_reg <= ST_R_RDR;
                        end
                        else
                        begin
                            state_reg <= ST_R_RDL;
                        end
                    end
                end
                ST_R_RDR:
                begin
                    state_reg <= ST_R_CMP;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_median_reg <= (lc_reg == '0) ? '0 : ltop_reg;
                        out_held_reg   <= held;
                        out_drop_reg   <= drop_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign median     = out_median_reg;
    assign held_count = out_held_reg;
    assign dropped    = out_drop_reg;

    // halves stay balanced between samples
    `RMTH_ASSERT_NOW(a_balance, state_reg == ST_IDLE,
        lc_reg == uc_reg || lc_reg == uc_reg + 1'b1)
    // store never exceeds capacity
    `RMTH_ASSERT_NOW(a_capacity, state_reg == ST_IDLE, held <= HW'(CAPACITY))
    // an accepted word starts work
    `RMTH_ASSERT_NEXT(a_start, in_valid && !in_stall, state_reg == ST_DECIDE)
    // a dropped result never changes the store
    `RMTH_ASSERT_NEXT(a_drop_hold, state_reg == ST_DECIDE && held >= HW'(CAPACITY),
        state_reg == ST_OUT && $stable(lc_reg) && $stable(uc_reg))

endmodule

// ===== design/rmth_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== bench/tb_running_median_two_heaps.sv =====
// Self-checking bench for running_median_two_heaps: a two-heap median predictor in the bench,
// directed and random sample words, random idling on both sides. Depends on rmth_pkg and the RTL.
`timescale 1ns / 1ps

module tb_running_median_two_heaps;

    localparam int CAP   = rmth_pkg::CAPACITY_DEF;
    localparam int SBITS = rmth_pkg::SAMPLE_BITS_DEF;
    localparam int HW    = $clog2(CAP + 1);
    localparam int HALF  = (CAP + 1) / 2;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [SBITS-1:0] median;
        logic [HW-1:0]           held_count;
        logic                    dropped;
    } median_word_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [SBITS-1:0] sample = '0;
    logic                    restart = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [SBITS-1:0] median;
    logic [HW-1:0]           held_count;
    logic                    dropped;

    // predictor state: max-heap of lower half, min-heap of upper half
    logic signed [SBITS-1:0] low_half [HALF];
    logic signed [SBITS-1:0] high_half [HALF];
    int                      low_n;
    int                      high_n;
    median_word_t            pending_medians [$];

    int send_idle_pct;
    int recv_idle_pct;
    int long_hold;
    int mismatches;
    int words_sent;
    int words_checked;
    int drops_seen;
    int quiet_cycles;

    running_median_two_heaps i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .median     (median),
        .held_count (held_count),
        .dropped    (dropped)
    );

    always #5 clk = ~clk;

    // heap order: in the max-heap a ranks above b when larger
    function automatic bit outranks(bit is_max, logic signed [SBITS-1:0] a,
                                    logic signed [SBITS-1:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_insert(bit is_max, logic signed [SBITS-1:0] v);
        int i;
        int p;
        i = is_max ? low_n : high_n;
        if (is_max) low_n++; else high_n++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (is_max)
            begin
                if (!outranks(1'b1, v, low_half[p])) break;
                low_half[i] = low_half[p];
            end
            else
            begin
                if (!outranks(1'b0, v, high_half[p])) break;
                high_half[i] = high_half[p];
            end
            i = p;
        end
        if (is_max) low_half[i] = v; else high_half[i] = v;
    endtask

    task automatic heap_swap_top(bit is_max, logic signed [SBITS-1:0] v);
        int i;
        int l;
        int r;
        int best;
        int n;
        logic signed [SBITS-1:0] bv;
        logic signed [SBITS-1:0] lv;
        logic signed [SBITS-1:0] rv;
        i = 0;
        n = is_max ? low_n : high_n;
        forever
        begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            best = i;
            bv = v;
            if (l < n)
            begin
                lv = is_max ? low_half[l] : high_half[l];
                if (outranks(is_max, lv, bv)) begin best = l; bv = lv; end
            end
            if (r < n)
            begin
                rv = is_max ? low_half[r] : high_half[r];
                if (outranks(is_max, rv, bv)) begin best = r; bv = rv; end
            end
            if (best == i) break;
            if (is_max) low_half[i] = bv; else high_half[i] = bv;
            i = best;
        end
        if (is_max) low_half[i] = v; else high_half[i] = v;
    endtask

    // add one sample to the predictor and queue the expected word
    task automatic predict_median(logic signed [SBITS-1:0] s, logic rs);
        median_word_t w;
        logic signed [SBITS-1:0] moved;
        w.dropped = 1'b0;
        if (rs)
        begin
            low_n = 0;
            high_n = 0;
        end
        if (low_n + high_n >= CAP)
            w.dropped = 1'b1;
        else if (low_n == 0 || s <= low_half[0])
        begin
            if (low_n > high_n)
            begin
                moved = low_half[0];
                heap_swap_top(1'b1, s);
                heap_insert(1'b0, moved);
            end
            else
                heap_insert(1'b1, s);
        end
        else if (high_n >= low_n)
        begin
            moved = s;
            if (high_n > 0 && s > high_half[0])
            begin
                moved = high_half[0];
                heap_swap_top(1'b0, s);
            end
            heap_insert(1'b1, moved);
        end
        else
            heap_insert(1'b0, s);
        w.median = (low_n > 0) ? low_half[0] : '0;
        w.held_count = HW'(low_n + high_n);
        pending_medians.push_back(w);
    endtask

    // offer one word and hold it until taken; valid is dropped by the next call when it idles, or at the end
    task automatic send_sample(logic signed [SBITS-1:0] s, logic rs);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        restart  <= rs;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_median(s, rs);
        words_sent++;
    endtask

    function automatic logic signed [SBITS-1:0] rand_sample();
        case ($urandom_range(5))
            0: return $signed(32'h8000_0000 + $urandom_range(3));
            1: return $signed(32'h7FFF_FFFF - $urandom_range(3));
            2: return $signed(SBITS'($urandom_range(16)) - SBITS'(8));
            default: return $signed($urandom());
        endcase
    endfunction

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (long_hold > 0)
        begin
            out_stall <= 1'b1;
            long_hold <= long_hold - 1;
        end
        else
            out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // compare each delivered word with the oldest prediction
    always @(posedge clk)
    begin
        median_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (dropped) drops_seen++;
            if (pending_medians.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: median %0d", median);
            end
            else
            begin
                w = pending_medians.pop_front();
                if (median !== w.median || held_count !== w.held_count
                    || dropped !== w.dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch word %0d: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 words_checked, w.median, w.held_count, w.dropped,
                                 median, held_count, dropped);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_extremes();
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'shAAAA_AAAA, 1'b0);
    endtask

    // ties with the lower top, swaps in both directions, restart mid-stream
    task automatic test_ties_and_rebalance();
        send_sample(10, 1'b1);
        send_sample(10, 1'b0);
        send_sample(10, 1'b0);
        send_sample(20, 1'b0);
        send_sample(30, 1'b0);
        send_sample(5, 1'b0);
        send_sample(1, 1'b0);
        send_sample(40, 1'b0);
        send_sample(25, 1'b0);
        send_sample(-7, 1'b1);
        send_sample(-7, 1'b0);
    endtask

    // fill the store, overflow, then restart while full
    task automatic test_full_store();
        send_sample(rand_sample(), 1'b1);
        for (int k = 1; k < CAP + 3; k++)
            send_sample(rand_sample(), 1'b0);
        send_sample(rand_sample(), 1'b1);
        send_sample(rand_sample(), 1'b0);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        long_hold = 300;
        for (int k = 0; k < 12; k++)
            send_sample(rand_sample(), 1'b0);
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
            send_sample(rand_sample(), ($urandom_range(99) < 3));
    endtask

    initial
    begin
        int guard;
        low_n = 0;
        high_n = 0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        drops_seen = 0;
        long_hold = 0;
        quiet_cycles = 0;
        send_idle_pct = 33;
        recv_idle_pct = 62;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_ties_and_rebalance();
        test_random(150);
        send_idle_pct = 62;
        recv_idle_pct = 33;
        test_backpressure();
        test_random(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_store();
        test_random(100);
        in_valid <= 1'b0;

        guard = 0;
        while (pending_medians.size() > 0 && guard < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        $display("Sent %0d samples, checked %0d medians, %0d on a full store.",
                 words_sent, words_checked, drops_seen);
        if (mismatches == 0 && pending_medians.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
